FILE: rtl/hrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_pkg
// shared types and constants of the histogram running median unit
// ----------------------------------------------------------------------------
package hrm_pkg;

  localparam int DEF_FEATURE_SLOTS = 256;
  localparam int DEF_MAX_COUNT     = 100;

  localparam int SLOT_IN_W  = 8;
  localparam int COUNT_IN_W = 8;
  localparam int MEDIAN_W   = 7;
  localparam int TOTAL_W    = 24;
  localparam int BIN_DATA_W = 24;

  typedef struct packed {
    logic [MEDIAN_W-1:0] median_value;
    logic                status;
  } hrm_res_t;

endpackage

FILE: rtl/hrm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_in_if / hrm_out_if
// valid/ready channels carrying feature updates and median results
// ----------------------------------------------------------------------------
interface hrm_in_if import hrm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SLOT_IN_W-1:0]  feature_slot;
  logic [COUNT_IN_W-1:0] feature_count;

  modport source (output valid, output feature_slot, output feature_count, input ready);
  modport sink   (input valid, input feature_slot, input feature_count, output ready);
  modport mon    (input valid, input feature_slot, input feature_count, input ready);
endinterface

interface hrm_out_if import hrm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MEDIAN_W-1:0] median_value;
  logic                status;

  modport source (output valid, output median_value, output status, input ready);
  modport sink   (input valid, input median_value, input status, output ready);
  modport mon    (input valid, input median_value, input status, input ready);
endinterface

FILE: rtl/hrm_bin_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_bin_ram
// single-port histogram bin memory, registered read data
// ----------------------------------------------------------------------------
module hrm_bin_ram import hrm_pkg::*; #(
  parameter int DEPTH  = DEF_FEATURE_SLOTS * (DEF_MAX_COUNT + 1),
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     addr_i,
  input  logic [BIN_DATA_W-1:0] wdata_i,
  output logic [BIN_DATA_W-1:0] rdata_o
);

  logic [BIN_DATA_W-1:0] mem [DEPTH];
  logic [BIN_DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/hrm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_seq
// sequencer: clear pass, bin increment and median walk over the bin memory
// ----------------------------------------------------------------------------
module hrm_seq import hrm_pkg::*; #(
  parameter int FEATURE_SLOTS = DEF_FEATURE_SLOTS,
  parameter int MAX_COUNT     = DEF_MAX_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [TOTAL_W-1:0]    region_total_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SLOT_IN_W-1:0]  in_slot_i,
  input  logic [COUNT_IN_W-1:0] in_count_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output hrm_res_t              res_o,
  output logic                  ram_we_o,
  output logic                  ram_re_o,
  output logic [$clog2(FEATURE_SLOTS*(MAX_COUNT+1))-1:0] ram_addr_o,
  output logic [BIN_DATA_W-1:0] ram_wdata_o,
  input  logic [BIN_DATA_W-1:0] ram_rdata_i
);

  localparam int NUM_BINS = MAX_COUNT + 1;
  localparam int DEPTH    = FEATURE_SLOTS * NUM_BINS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SLOT_W   = (FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1;
  localparam int BIN_W    = $clog2(NUM_BINS + 1);
  localparam int ACC_W    = BIN_DATA_W + BIN_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_BASE  = 7'b0000100,
    S_RD    = 7'b0001000,
    S_WR    = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                  state_q, state_d;
  logic [ADDR_W-1:0]       clr_q, clr_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [COUNT_IN_W-1:0]   cnt_q, cnt_d;
  logic                    err_q, err_d;
  logic [ADDR_W-1:0]       base_q, base_d;
  logic [BIN_W-1:0]        ib_q, ib_d;
  logic [BIN_W-1:0]        db_q, db_d;
  logic                    rv_q, rv_d;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [BIN_W-1:0]        med_q, med_d;
  logic [TOTAL_W-1:0]      limit;
  logic [ACC_W-1:0]        sum;
  logic [BIN_DATA_W-1:0]   bin_inc;

  // slot modulo the slot count, restoring remainder over the 8 input bits
  function automatic logic [12:0] slot_mod(input logic [SLOT_IN_W-1:0] v);
    logic [13:0] rem;
    rem = '0;
    for (int i = SLOT_IN_W - 1; i >= 0; i--) begin
      rem = {rem[12:0], v[i]};
      if (rem >= 14'(FEATURE_SLOTS)) begin
        rem = rem - 14'(FEATURE_SLOTS);
      end
    end
    return rem[12:0];
  endfunction

  assign limit   = {1'b0, region_total_i[TOTAL_W-1:1]} + TOTAL_W'(1);
  assign sum     = acc_q + ACC_W'(ram_rdata_i);
  assign bin_inc = (&ram_rdata_i) ? ram_rdata_i : ram_rdata_i + BIN_DATA_W'(1);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    slot_d  = slot_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    base_d  = base_q;
    ib_d    = ib_q;
    db_d    = db_q;
    rv_d    = 1'b0;
    acc_d   = acc_q;
    med_d   = med_q;

    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = base_q + ADDR_W'(cnt_q);
    ram_wdata_o = bin_inc;

    unique case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          slot_d  = SLOT_W'(slot_mod(in_slot_i));
          cnt_d   = in_count_i;
          err_d   = (in_count_i > COUNT_IN_W'(MAX_COUNT));
          state_d = S_BASE;
        end
      end
      S_BASE: begin
        base_d = ADDR_W'(slot_q) * ADDR_W'(NUM_BINS);
        ib_d   = '0;
        db_d   = '0;
        acc_d  = '0;
        state_d = err_q ? S_WALK : S_RD;
      end
      S_RD: begin
        ram_re_o = 1'b1;
        state_d  = S_WR;
      end
      S_WR: begin
        // read data of the count's bin is here, write back saturated
        ram_we_o = 1'b1;
        state_d  = S_WALK;
      end
      S_WALK: begin
        ram_re_o   = 1'b1;
        ram_addr_o = base_q + ADDR_W'(ib_q);
        rv_d       = 1'b1;
        if (ib_q != BIN_W'(MAX_COUNT)) begin
          ib_d = ib_q + BIN_W'(1);
        end
        if (rv_q) begin
          if (sum > ACC_W'(limit)) begin
            med_d   = db_q;
            rv_d    = 1'b0;
            state_d = S_DONE;
          end else if (db_q == BIN_W'(MAX_COUNT)) begin
            med_d   = BIN_W'(NUM_BINS);
            rv_d    = 1'b0;
            state_d = S_DONE;
          end else begin
            acc_d = sum;
            db_d  = db_q + BIN_W'(1);
          end
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ib_q    <= '0;
      db_q    <= '0;
      rv_q    <= 1'b0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ib_q    <= ib_d;
      db_q    <= db_d;
      rv_q    <= rv_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    cnt_q  <= cnt_d;
    err_q  <= err_d;
    base_q <= base_d;
    med_q  <= med_d;
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign res_valid_o        = (state_q == S_DONE);
  assign res_o.median_value = MEDIAN_W'(med_q);
  assign res_o.status       = err_q;

endmodule

FILE: rtl/histogram_running_median_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_running_median_unit
// per-feature count histograms with a running median lookup
// ----------------------------------------------------------------------------
// Each input beat names a feature slot and that feature's count in one region.
// The unit adds one to the slot's histogram bin for that count (bins saturate
// at 2^24-1; a count above MAX_COUNT changes nothing and returns status 1),
// then walks the slot's bins from bin 0 and returns the first bin at which
// the running sum exceeds region_total/2+1, or MAX_COUNT+1 if none does. All
// bins live in one single-port memory of FEATURE_SLOTS*(MAX_COUNT+1) words.
// After reset a clearing pass writes zero to every word, one per cycle; no
// input beat is taken until it ends, while region_total may be written at
// any time. One item at a time: no new beat is taken while an item is in
// flight; a count past the bin limit skips the bin update, the walk stops
// at the median bin, and the single memory read port sets the pace. The
// next beat is taken in the cycle after the result is handed to the output
// register, so a result waiting downstream does not hold up the next item.
// ----------------------------------------------------------------------------
module histogram_running_median_unit import hrm_pkg::*; #(
  parameter int FEATURE_SLOTS = DEF_FEATURE_SLOTS,
  parameter int MAX_COUNT     = DEF_MAX_COUNT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TOTAL_W-1:0] cfg_wdata_i,
  hrm_in_if.sink             feat_i,
  hrm_out_if.source          med_o
);

  localparam int DEPTH  = FEATURE_SLOTS * (MAX_COUNT + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  // region total register, sets the median threshold
  logic [TOTAL_W-1:0]    region_total_q;

  // output register
  logic                  out_valid_q;
  hrm_res_t              out_res_q;

  // sequencer result handoff
  logic                  res_valid;
  logic                  res_ready;
  hrm_res_t              res;

  // bin memory port
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_addr;
  logic [BIN_DATA_W-1:0] ram_wdata;
  logic [BIN_DATA_W-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_total_q <= '0;
    end else if (cfg_we_i) begin
      region_total_q <= cfg_wdata_i;
    end
  end

  // output stage is free when empty or being drained this cycle
  assign res_ready = !out_valid_q || med_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign med_o.valid        = out_valid_q;
  assign med_o.median_value = out_res_q.median_value;
  assign med_o.status       = out_res_q.status;

  hrm_seq #(
    .FEATURE_SLOTS (FEATURE_SLOTS),
    .MAX_COUNT     (MAX_COUNT)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .region_total_i (region_total_q),
    .in_valid_i     (feat_i.valid),
    .in_ready_o     (feat_i.ready),
    .in_slot_i      (feat_i.feature_slot),
    .in_count_i     (feat_i.feature_count),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .ram_we_o       (ram_we),
    .ram_re_o       (ram_re),
    .ram_addr_o     (ram_addr),
    .ram_wdata_o    (ram_wdata),
    .ram_rdata_i    (ram_rdata)
  );

  hrm_bin_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: rtl/hrm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrm_checker
// port-level checks of the histogram running median unit
// ----------------------------------------------------------------------------
module hrm_checker import hrm_pkg::*; #(
  parameter int MAX_COUNT = DEF_MAX_COUNT
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                feat_valid_i,
  input logic                feat_ready_i,
  input logic                med_valid_i,
  input logic                med_ready_i,
  input logic [MEDIAN_W-1:0] med_value_i,
  input logic                med_status_i
);

  // result beat holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    med_valid_i && !med_ready_i |=> med_valid_i && $stable(med_value_i)
      && $stable(med_status_i))
    else $error("result beat changed while stalled");

  // one item in flight: no beat right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    feat_valid_i && feat_ready_i |=> !feat_ready_i)
    else $error("input taken while an item is in flight");

  // a new result never appears while the input side was open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(med_valid_i) |-> $past(!feat_ready_i))
    else $error("result without an item in flight");

  // median never exceeds the no-median marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    med_valid_i |-> (MAX_COUNT > 126) || (int'(med_value_i) <= MAX_COUNT + 1))
    else $error("median out of range");

endmodule

bind histogram_running_median_unit hrm_checker #(
  .MAX_COUNT (MAX_COUNT)
) u_hrm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .feat_valid_i (feat_i.valid),
  .feat_ready_i (feat_i.ready),
  .med_valid_i  (med_o.valid),
  .med_ready_i  (med_o.ready),
  .med_value_i  (med_o.median_value),
  .med_status_i (med_o.status)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the histogram running median unit
// ----------------------------------------------------------------------------
// A short table of directed updates covers empty slots, the top slot, the
// first and last bins, counts past the bin limit and region_total extremes.
// Random updates follow in several phases, each with its own region_total and
// each written while the unit is idle. The updates go mostly to a few hot
// slots so that their histograms fill up and the median moves. A local
// histogram model predicts every result beat, and the output monitor checks
// each beat against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import hrm_pkg::*;

  localparam int FEATURE_SLOTS = DEF_FEATURE_SLOTS;
  localparam int MAX_COUNT     = DEF_MAX_COUNT;
  localparam int NUM_BINS      = MAX_COUNT + 1;
  localparam int HOT_SLOTS     = 8;
  localparam int PHASES        = 10;
  localparam int PHASE_UPDATES = 170;
  localparam int DIR_ROWS      = 23;

  // status codes of a result beat
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // median reported when the walk never passes the threshold
  localparam logic [MEDIAN_W-1:0]   MED_NONE = MEDIAN_W'(NUM_BINS);
  localparam logic [BIN_DATA_W-1:0] BIN_FULL = {BIN_DATA_W{1'b1}};
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic {ROW_UPD, ROW_CFG} row_kind_e;

  // one line of the directed table; exp is used only where has_exp is set
  typedef struct packed {
    row_kind_e             kind;
    logic [SLOT_IN_W-1:0]  slot;
    logic [COUNT_IN_W-1:0] count;
    logic [TOTAL_W-1:0]    total;
    logic                  has_exp;
    hrm_res_t              exp;
  } dir_row_t;

  // region_total is 0 after reset, so the threshold starts at 1
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // one entry in an empty slot never passes the threshold
    '{ROW_UPD, 8'd0,   8'd0,   24'd0, 1'b1, '{MED_NONE,  ST_OK}},
    '{ROW_UPD, 8'd0,   8'd0,   24'd0, 1'b1, '{7'd0,      ST_OK}},
    // top slot, top bin
    '{ROW_UPD, 8'd255, 8'd100, 24'd0, 1'b1, '{MED_NONE,  ST_OK}},
    '{ROW_UPD, 8'd255, 8'd100, 24'd0, 1'b1, '{7'd100,    ST_OK}},
    // counts past the bin limit leave the histogram alone
    '{ROW_UPD, 8'd255, 8'd101, 24'd0, 1'b1, '{7'd100,    ST_RANGE}},
    '{ROW_UPD, 8'd255, 8'd255, 24'd0, 1'b1, '{7'd100,    ST_RANGE}},
    '{ROW_UPD, 8'd170, 8'd255, 24'd0, 1'b1, '{MED_NONE,  ST_RANGE}},
    '{ROW_UPD, 8'd85,  8'd128, 24'd0, 1'b1, '{MED_NONE,  ST_RANGE}},
    '{ROW_UPD, 8'd85,  8'd127, 24'd0, 1'b1, '{MED_NONE,  ST_RANGE}},
    '{ROW_UPD, 8'd1,   8'd50,  24'd0, 1'b0, '{7'd0,      ST_OK}},
    '{ROW_UPD, 8'd1,   8'd30,  24'd0, 1'b0, '{7'd0,      ST_OK}},
    '{ROW_UPD, 8'd1,   8'd1,   24'd0, 1'b0, '{7'd0,      ST_OK}},
    // largest region_total, threshold out of reach
    '{ROW_CFG, 8'd0,   8'd0,   TOTAL_MAX, 1'b0, '{7'd0,  ST_OK}},
    '{ROW_UPD, 8'd0,   8'd0,   24'd0, 1'b1, '{MED_NONE,  ST_OK}},
    '{ROW_UPD, 8'd255, 8'd0,   24'd0, 1'b1, '{MED_NONE,  ST_OK}},
    '{ROW_CFG, 8'd0,   8'd0,   24'd1, 1'b0, '{7'd0,      ST_OK}},
    '{ROW_UPD, 8'd1,   8'd99,  24'd0, 1'b0, '{7'd0,      ST_OK}},
    '{ROW_UPD, 8'd0,   8'd0,   24'd0, 1'b1, '{7'd0,      ST_OK}},
    '{ROW_CFG, 8'd0,   8'd0,   24'd6, 1'b0, '{7'd0,      ST_OK}},
    '{ROW_UPD, 8'd1,   8'd70,  24'd0, 1'b0, '{7'd0,      ST_OK}},
    '{ROW_UPD, 8'd254, 8'd100, 24'd0, 1'b0, '{7'd0,      ST_OK}},
    '{ROW_CFG, 8'd0,   8'd0,   24'd0, 1'b0, '{7'd0,      ST_OK}},
    '{ROW_UPD, 8'd127, 8'd64,  24'd0, 1'b0, '{7'd0,      ST_OK}}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [TOTAL_W-1:0] cfg_wdata_i;

  hrm_in_if  feat_if ();
  hrm_out_if med_if ();

  histogram_running_median_unit #(
    .FEATURE_SLOTS (FEATURE_SLOTS),
    .MAX_COUNT     (MAX_COUNT)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .feat_i      (feat_if.sink),
    .med_o       (med_if.source)
  );

  // model state: one histogram per slot plus the region_total register
  bit   [BIN_DATA_W-1:0] hist_bins [FEATURE_SLOTS][NUM_BINS];
  logic [TOTAL_W-1:0]    total_cfg;

  hrm_res_t        median_q [$];   // predicted result beats, oldest first
  int              err_count;
  int unsigned     burst_left;     // beats left in the current input burst
  int unsigned     ready_hold;     // cycles the output ready keeps its level
  logic [SLOT_IN_W-1:0] hot_slots [HOT_SLOTS];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // bump the bin for this count, then walk the slot up from bin 0
  function automatic hrm_res_t apply_update(input logic [SLOT_IN_W-1:0] slot,
                                            input logic [COUNT_IN_W-1:0] count);
    int unsigned     s;
    int unsigned     med;
    longint unsigned acc;
    longint unsigned thresh;
    hrm_res_t        res;
    s = slot % FEATURE_SLOTS;
    res.status = (count > MAX_COUNT) ? ST_RANGE : ST_OK;
    // bins saturate instead of wrapping
    if (res.status == ST_OK && hist_bins[s][count] != BIN_FULL) begin
      hist_bins[s][count] = hist_bins[s][count] + 1'b1;
    end
    thresh = (total_cfg >> 1) + 1;
    acc    = 0;
    med    = NUM_BINS;
    for (int b = 0; b < NUM_BINS; b++) begin
      if (med == NUM_BINS) begin
        acc += hist_bins[s][b];
        if (acc > thresh) begin
          med = b;
        end
      end
    end
    res.median_value = med[MEDIAN_W-1:0];
    return res;
  endfunction

  // region_total is written only with no result outstanding
  task automatic write_total(input logic [TOTAL_W-1:0] value);
    feat_if.valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    total_cfg = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one input beat; the sender runs in bursts with random gaps in between
  task automatic send_update(input logic [SLOT_IN_W-1:0] slot,
                             input logic [COUNT_IN_W-1:0] count,
                             input logic has_exp,
                             input hrm_res_t exp);
    int unsigned gap;
    hrm_res_t    pred;
    if (burst_left == 0) begin
      // long gaps now and then, so the sender also idles past a whole walk
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 120) : $urandom_range(0, 15);
      if (gap != 0) begin
        feat_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
    end
    feat_if.valid         <= 1'b1;
    feat_if.feature_slot  <= slot;
    feat_if.feature_count <= count;
    do @(posedge clk_i); while (!feat_if.ready);
    pred = apply_update(slot, count);
    median_q.push_back(has_exp ? exp : pred);
    burst_left--;
    @(negedge clk_i);
  endtask

  // output stall pattern: long open stretches mixed with short on/off runs
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      med_if.ready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          med_if.ready <= 1'b1;
          ready_hold   <= $urandom_range(20, 80);
        end
        1, 2: begin
          med_if.ready <= 1'b1;
          ready_hold   <= $urandom_range(0, 5);
        end
        default: begin
          med_if.ready <= 1'b0;
          ready_hold   <= $urandom_range(0, 10);
        end
      endcase
    end
  end

  // every result beat is matched against the oldest prediction
  always @(posedge clk_i) begin : result_check
    hrm_res_t want;
    if (rst_ni && med_if.valid && med_if.ready) begin
      if (median_q.size() == 0) begin
        $error("result beat with nothing expected: median_value %0d status %0d",
               med_if.median_value, med_if.status);
        err_count++;
      end else begin
        want = median_q.pop_front();
        if (med_if.median_value !== want.median_value) begin
          $error("median_value: expected %0d, got %0d", want.median_value,
                 med_if.median_value);
          err_count++;
        end
        if (med_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, med_if.status);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [SLOT_IN_W-1:0]  slot;
    logic [COUNT_IN_W-1:0] count;
    logic [TOTAL_W-1:0]    total;
    int unsigned           pick;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    feat_if.valid         = 1'b0;
    feat_if.feature_slot  = '0;
    feat_if.feature_count = '0;
    med_if.ready          = 1'b0;
    total_cfg             = '0;
    err_count             = 0;
    burst_left            = 0;
    ready_hold            = 0;
    foreach (hot_slots[i]) hot_slots[i] = SLOT_IN_W'($urandom_range(0, FEATURE_SLOTS - 1));
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // the clearing pass after reset simply shows up as a long wait for ready

    // directed part
    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        write_total(DIR_TABLE[i].total);
      end else begin
        send_update(DIR_TABLE[i].slot, DIR_TABLE[i].count, DIR_TABLE[i].has_exp,
                    DIR_TABLE[i].exp);
      end
    end

    // random part: one region_total per phase, extremes included
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       total = '0;
        1:       total = 24'd1;
        2:       total = TOTAL_MAX;
        3:       total = TOTAL_W'($urandom_range(2, 40));
        4:       total = TOTAL_W'($urandom_range(40, 200));
        5:       total = TOTAL_W'($urandom_range(200, 600));
        6:       total = TOTAL_W'($urandom_range(0, TOTAL_MAX));
        7:       total = TOTAL_W'($urandom_range(2, 300));
        8:       total = TOTAL_W'($urandom_range(0, 30));
        default: total = 24'd2;
      endcase
      write_total(total);
      repeat (PHASE_UPDATES) begin
        // mostly hot slots so their histograms fill; any slot now and then
        slot = ($urandom_range(0, 4) != 0)
             ? hot_slots[$urandom_range(0, HOT_SLOTS - 1)]
             : SLOT_IN_W'($urandom_range(0, FEATURE_SLOTS - 1));
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          count = COUNT_IN_W'($urandom_range(MAX_COUNT + 1, 255));   // past the bin limit
        end else if (pick == 2) begin
          // first or last bin
          count = $urandom_range(0, 1) ? COUNT_IN_W'(MAX_COUNT) : '0;
        end else begin
          count = COUNT_IN_W'($urandom_range(0, MAX_COUNT));
        end
        send_update(slot, count, 1'b0, '0);
      end
    end

    feat_if.valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    // catch any stray beat after the last expected one
    repeat (MAX_COUNT + 20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/hrm_pkg.sv
rtl/hrm_if.sv
rtl/hrm_bin_ram.sv
rtl/hrm_seq.sv
rtl/histogram_running_median_unit.sv
rtl/hrm_checker.sv
sim/tb.sv
